// File: rtl/core/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
package uer_pkg;

  localparam int unsigned DIST_W    = 14;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAP     = 2'd1;

  localparam logic [CFG_W-1:0] TIMEOUT_RST = 16'd3800;
  localparam logic [CFG_W-1:0] GAP_RST     = 16'd5000;

  localparam logic [DIST_W-1:0] DIST_MAX = 14'h3FFF;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT,
    PH_HIGH,
    PH_GAP
  } phase_t;

  typedef struct packed {
    logic start_req;
    logic echo;
  } in_item_t;

  typedef struct packed {
    logic              trigger;
    logic              busy_res;
    logic              distance_valid;
    logic [DIST_W-1:0] distance_cm;
    logic              timed_out;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] timeout_ticks;
    logic [CFG_W-1:0] gap_ticks;
  } cfg_t;

endpackage

// File: rtl/core/uer_dist.sv
// Echo width to centimetre scaler: constant reciprocal multiply with saturation.
module uer_dist #(
  parameter int unsigned TICK_US     = 10,
  parameter int unsigned US_PER_CM   = 46,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic [COUNT_WIDTH-1:0]          width_ticks,
  output logic [uer_pkg::DIST_W-1:0]      distance_cm
);

  // Products below DLIM give a quotient under 2^DIST_W; at or above it we saturate.
  localparam longint unsigned DLIM = (64'd1 << uer_pkg::DIST_W) * US_PER_CM;
  localparam int unsigned     NB   = $clog2(DLIM);
  localparam int unsigned     LB   = $clog2(US_PER_CM);
  localparam int unsigned     SH   = NB + LB;
  localparam longint unsigned RECIP = ((64'd1 << SH) + US_PER_CM - 1) / US_PER_CM;
  localparam longint unsigned KMUL = RECIP * TICK_US;
  localparam int unsigned     KW   = $clog2(KMUL + 1);
  localparam longint unsigned CLIM = (DLIM + TICK_US - 1) / TICK_US;
  localparam int unsigned     PW   = COUNT_WIDTH + KW;

  logic          sat;
  logic [PW-1:0] prod;
  logic [PW-1:0] quot;

  assign sat  = {{(64-COUNT_WIDTH){1'b0}}, width_ticks} >= CLIM;
  assign prod = PW'(width_ticks) * PW'(KMUL);
  assign quot = prod >> SH;

  assign distance_cm = sat ? uer_pkg::DIST_MAX : quot[uer_pkg::DIST_W-1:0];

endmodule

// File: rtl/core/uer_seq.sv
// Ranging sequencer: phase register, tick counter and per-tick result.
module uer_seq #(
  parameter int unsigned TICK_US     = 10,
  parameter int unsigned US_PER_CM   = 46,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  uer_pkg::in_item_t  item,
  input  uer_pkg::cfg_t      cfg,
  output uer_pkg::out_item_t res
);

  localparam int unsigned CNT_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam logic [CNT_W-1:0] SAT16     = CNT_W'(16'hFFFF);
  localparam logic [CNT_W-1:0] WIDTH_SAT = CNT_W'((64'd1 << COUNT_WIDTH) - 64'd1);

  uer_pkg::phase_t phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             succ_r, succ_nxt;

  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] sat16_inc;
  logic [CNT_W-1:0] high_inc;
  logic             gap_done;
  logic             tmo;
  logic             to_idle;
  logic [uer_pkg::DIST_W-1:0] dist_cm;

  assign cnt_inc   = cnt_r + CNT_W'(1);
  assign sat16_inc = (cnt_r < SAT16) ? cnt_inc : cnt_r;
  assign high_inc  = (cnt_r < WIDTH_SAT) ? cnt_inc : cnt_r;
  assign gap_done  = cnt_r >= CNT_W'(cfg.gap_ticks);
  // a zero timeout behaves as one since the bumped count is always >= 0
  assign tmo       = sat16_inc >= CNT_W'(cfg.timeout_ticks);
  assign to_idle   = (phase_r == uer_pkg::PH_IDLE) ||
                     ((phase_r == uer_pkg::PH_GAP) && gap_done && succ_r);

  uer_dist #(
    .TICK_US    (TICK_US),
    .US_PER_CM  (US_PER_CM),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dist (
    .width_ticks(cnt_r[COUNT_WIDTH-1:0]),
    .distance_cm(dist_cm)
  );

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      uer_pkg::PH_IDLE: begin
        phase_nxt = item.start_req ? uer_pkg::PH_WAIT : uer_pkg::PH_IDLE;
      end
      uer_pkg::PH_WAIT: begin
        if (item.echo) begin
          phase_nxt = uer_pkg::PH_HIGH;
        end else if (tmo) begin
          phase_nxt = uer_pkg::PH_GAP;
        end
      end
      uer_pkg::PH_HIGH: begin
        phase_nxt = item.echo ? uer_pkg::PH_HIGH : uer_pkg::PH_GAP;
      end
      uer_pkg::PH_GAP: begin
        if (gap_done) begin
          if (!succ_r) begin
            phase_nxt = uer_pkg::PH_WAIT;
          end else begin
            phase_nxt = item.start_req ? uer_pkg::PH_WAIT : uer_pkg::PH_IDLE;
          end
        end
      end
      default: phase_nxt = uer_pkg::PH_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt      = cnt_r;
    succ_nxt     = succ_r;
    res          = '0;
    res.busy_res = 1'b1;
    unique case (phase_r)
      uer_pkg::PH_IDLE: begin
        cnt_nxt = cnt_r;
      end
      uer_pkg::PH_WAIT: begin
        if (item.echo) begin
          cnt_nxt = CNT_W'(1);
        end else if (tmo) begin
          res.timed_out = 1'b1;
          succ_nxt      = 1'b0;
          cnt_nxt       = '0;
        end else begin
          cnt_nxt = sat16_inc;
        end
      end
      uer_pkg::PH_HIGH: begin
        if (item.echo) begin
          cnt_nxt = high_inc;
        end else begin
          res.distance_valid = 1'b1;
          res.distance_cm    = dist_cm;
          succ_nxt           = 1'b1;
          cnt_nxt            = '0;
        end
      end
      uer_pkg::PH_GAP: begin
        if (gap_done) begin
          if (!succ_r) begin
            // retry after a timeout
            res.trigger = 1'b1;
            cnt_nxt     = '0;
          end
        end else begin
          cnt_nxt = sat16_inc;
        end
      end
      default: cnt_nxt = cnt_r;
    endcase

    // idle tick, including the tick that closes a successful hold-off
    if (to_idle) begin
      res.busy_res = 1'b0;
      if (item.start_req) begin
        res.trigger  = 1'b1;
        res.busy_res = 1'b1;
        cnt_nxt      = '0;
        succ_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= uer_pkg::PH_IDLE;
      cnt_r   <= '0;
      succ_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      succ_r  <= succ_nxt;
    end
  end

  a_high_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == uer_pkg::PH_HIGH) |-> (cnt_r != '0))
    else $error("echo-high phase with zero width count");

  a_trig_to_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.trigger) |=> (phase_r == uer_pkg::PH_WAIT))
    else $error("trigger not followed by echo wait");

endmodule

// File: rtl/core/ultrasonic_echo_ranger_top.sv
// Ultrasonic echo ranger: input register, sequencer, result register, config registers.
// A transferred tick waits in the input register and moves to the result register, offered on out_*, when not stalled.
// Throughput: one tick per cycle while out_stall is low; the sequencer updates phase and counter together per tick.
// Stall on the result side backs up through the input register to in_stall.
// Reset (synchronous, rst_n low): sequencer idle, counters cleared, both
// pipeline stages empty, timeout_ticks = 3800 and gap_ticks = 5000.
module ultrasonic_echo_ranger_top #(
  parameter int unsigned TICK_US     = 10,
  parameter int unsigned US_PER_CM   = 46,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  uer_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output uer_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [uer_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [uer_pkg::CFG_W-1:0]         cfg_data
);

  logic               in_valid_r, in_valid_nxt;
  uer_pkg::in_item_t  in_data_r;
  logic               out_valid_r;
  uer_pkg::out_item_t out_data_r;
  uer_pkg::cfg_t      cfg_r, cfg_nxt;
  uer_pkg::out_item_t res;

  logic advance;
  logic fire;
  logic in_xfer;

  assign advance   = !out_valid_r || !out_stall;
  assign fire      = in_valid_r && advance;
  assign in_stall  = in_valid_r && !advance;
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_xfer) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        uer_pkg::CFG_IDX_TIMEOUT: cfg_nxt.timeout_ticks = cfg_data;
        uer_pkg::CFG_IDX_GAP:     cfg_nxt.gap_ticks     = cfg_data;
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  uer_seq #(
    .TICK_US    (TICK_US),
    .US_PER_CM  (US_PER_CM),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .step (fire),
    .item (in_data_r),
    .cfg  (cfg_r),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r          <= 1'b0;
      out_valid_r         <= 1'b0;
      cfg_r.timeout_ticks <= uer_pkg::TIMEOUT_RST;
      cfg_r.gap_ticks     <= uer_pkg::GAP_RST;
    end else begin
      in_valid_r <= in_valid_nxt;
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
      cfg_r <= cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_data_r <= in_data;
    end
    if (fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_valid_r && out_valid_r))
    else $error("input stalled with room downstream");

  a_res_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.distance_valid && out_data_r.timed_out))
    else $error("distance and timeout flagged on one tick");

  a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.trigger) |-> out_data_r.busy_res)
    else $error("trigger driven while not busy");

endmodule
